>>> rtl/qxmix_pkg.sv
// Package with shared types and constants of the X-frame motor mixer.
`default_nettype none

package qxmix_pkg;

   // Fixed-point format: percent times 2**FRAC_BITS.
   localparam int FRAC_BITS  = 8;
   localparam int ONE_VAL    = 1 << FRAC_BITS;
   localparam int FULL_VAL   = 100 * ONE_VAL;

   // Field widths.
   localparam int PCT_W      = 15;
   localparam int CMD_W      = 18;
   localparam int NUM_MOTORS = 4;

   // Working width covers mixing and desaturation of the extreme inputs.
   localparam int WORK_W     = 22;

   localparam logic [PCT_W-1:0] IDLE_RESET = PCT_W'(1280);

   // Motor order: rear right, front right, rear left, front left.
   localparam int M_RR = 0;
   localparam int M_FR = 1;
   localparam int M_RL = 2;
   localparam int M_FL = 3;

   typedef logic signed [WORK_W-1:0] work_type;
   typedef work_type motors_type [NUM_MOTORS];
   typedef logic [PCT_W-1:0] pct_type;

   // Throttle conditions carried along the pipeline.
   typedef struct packed {
      logic raise_ok;  // throttle above 1 %
      logic cut;       // throttle below 1 %
   } thr_flags_type;

endpackage

`default_nettype wire

>>> rtl/quad_x_motor_mixer_desaturate_top.sv
// Top level of the quadcopter X-frame motor mixer with desaturation.
`default_nettype none

// The mixer takes one request per clock cycle while the result side is not
// stalled, and returns one result per request through its registers:
// an input register, a register after mixing, a register after desaturation
// and the result register form a four-stage pipeline. Each stage has its own
// valid bit and loads whenever it is empty or its successor loads, so empty
// stages are filled even while a finished result waits. The idle level is
// written through the csr port and resets to 5 %; write it only while no
// request is in flight.

module quad_x_motor_mixer_desaturate_top
   import qxmix_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic [14:0] csr_wr_data,   // idle_level

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [14:0] throttle, [32:15] roll_cmd, [50:33] pitch_cmd, [68:51] yaw_cmd, [71:69] zero
   input  wire logic [71:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [14:0] motor_rear_right, [29:15] motor_front_right,
   // [44:30] motor_rear_left, [59:45] motor_front_left, [63:60] zero
   output logic [63:0]      rsp_tdata
);

   // Configuration register.
   pct_type idle_ff;

   // Stage 1: input register.
   logic                    v1_ff;
   pct_type                 t1_ff;
   logic signed [CMD_W-1:0] r1_ff;
   logic signed [CMD_W-1:0] p1_ff;
   logic signed [CMD_W-1:0] y1_ff;

   // Stage 2: mixed commands.
   logic          v2_ff;
   motors_type    mix2_ff;
   motors_type    mix2_in;
   thr_flags_type flags2_ff;
   thr_flags_type flags2_in;

   // Stage 3: desaturated commands.
   logic          v3_ff;
   motors_type    desat3_ff;
   motors_type    desat3_in;
   work_type      lo3_ff;
   work_type      lo3_in;
   thr_flags_type flags3_ff;

   // Result register.
   logic    vo_ff;
   pct_type mot_ff [NUM_MOTORS];
   pct_type mot_in [NUM_MOTORS];

   // Stage load enables.
   logic en_out;
   logic en3;
   logic en2;
   logic en1;

   work_type t_w;
   work_type r_w;
   work_type p_w;
   work_type y_w;
   work_type idle_w;
   work_type up;
   logic     need_up;

   // A stage loads when it is empty or its content moves on.
   assign en_out     = !vo_ff || rsp_tready;
   assign en3        = !v3_ff || en_out;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   // Idle level register.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= IDLE_RESET;
      end else if (csr_wr_en) begin
         idle_ff <= csr_wr_data;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en_out) begin
            vo_ff <= v3_ff;
         end
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (en1 && req_tvalid) begin
         t1_ff <= req_tdata[14:0];
         r1_ff <= req_tdata[32:15];
         p1_ff <= req_tdata[50:33];
         y1_ff <= req_tdata[68:51];
      end
   end

   // Quarter scaling by arithmetic shift and X-frame mixing.
   assign t_w = work_type'({1'b0, t1_ff});
   assign r_w = work_type'(r1_ff >>> 2);
   assign p_w = work_type'(p1_ff >>> 2);
   assign y_w = work_type'(y1_ff >>> 2);

   always_comb begin
      mix2_in[M_RR] = t_w - r_w - p_w + y_w;
      mix2_in[M_FR] = t_w - r_w + p_w - y_w;
      mix2_in[M_RL] = t_w + r_w - p_w - y_w;
      mix2_in[M_FL] = t_w + r_w + p_w + y_w;
      flags2_in.raise_ok = t_w > work_type'(ONE_VAL);
      flags2_in.cut      = t_w < work_type'(ONE_VAL);
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         mix2_ff   <= mix2_in;
         flags2_ff <= flags2_in;
      end
   end

   // Desaturation against the 100 % ceiling.
   qxmix_desat u_desat (
      .mix   (mix2_ff),
      .desat (desat3_in),
      .lo    (lo3_in)
   );

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         desat3_ff <= desat3_in;
         lo3_ff    <= lo3_in;
         flags3_ff <= flags2_ff;
      end
   end

   // Raise to idle level, clamp to 0..100 % and cut at low throttle.
   assign idle_w  = work_type'({1'b0, idle_ff});
   assign need_up = flags3_ff.raise_ok && (lo3_ff < idle_w);
   assign up      = need_up ? (idle_w - lo3_ff) : '0;

   always_comb begin
      work_type m;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         m = desat3_ff[i] + up;
         if (m > work_type'(FULL_VAL)) begin
            m = work_type'(FULL_VAL);
         end
         if (m < 0) begin
            m = '0;
         end
         if (flags3_ff.cut) begin
            m = '0;
         end
         mot_in[i] = m[PCT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && v3_ff) begin
         mot_ff <= mot_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {4'b0, mot_ff[M_FL], mot_ff[M_RL], mot_ff[M_FR], mot_ff[M_RR]};

   // Ready drops only when every stage holds a request.
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && vo_ff))
      else $error("request side stalled with an empty stage");

   // Results never exceed 100 %.
   a_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mot_ff[M_RR] <= PCT_W'(FULL_VAL) && mot_ff[M_FR] <= PCT_W'(FULL_VAL)
                   && mot_ff[M_RL] <= PCT_W'(FULL_VAL) && mot_ff[M_FL] <= PCT_W'(FULL_VAL)))
      else $error("motor command above full scale");

   // Low throttle forces all four commands to zero.
   a_cut: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en_out && flags3_ff.cut) |=> (rsp_tdata == '0))
      else $error("low throttle did not stop the motors");

   // Throttle flags are never both set.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> !(flags3_ff.cut && flags3_ff.raise_ok))
      else $error("contradictory throttle flags");

   // No result right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

>>> rtl/qxmix_desat.sv
// Desaturation: finds the extremes of the mixed commands and removes any excess above 100 %.
`default_nettype none

module qxmix_desat
   import qxmix_pkg::*;
(
   input  wire motors_type mix,
   output motors_type desat,
   output work_type   lo
);

   work_type hi_max;
   work_type lo_min;
   work_type excess;
   logic     over;

   // Largest and smallest of the four commands.
   always_comb begin
      hi_max = mix[0];
      lo_min = mix[0];
      for (int i = 1; i < NUM_MOTORS; i++) begin
         if (mix[i] > hi_max) begin
            hi_max = mix[i];
         end
         if (mix[i] < lo_min) begin
            lo_min = mix[i];
         end
      end
   end

   // Lower all commands together by the amount the largest exceeds 100 %.
   assign over   = hi_max > work_type'(FULL_VAL);
   assign excess = over ? (hi_max - work_type'(FULL_VAL)) : '0;

   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         desat[i] = mix[i] - excess;
      end
   end

   assign lo = lo_min - excess;

endmodule

`default_nettype wire
